@@ sv/lzsu_pkg.sv @@
// Shared types, constants and the output alphabet for the lz-string URI compressor.
package lzsu_pkg;

	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;
	localparam int HASH_SHIFT = 24;
	localparam int MUL_DIGIT = 11;
	localparam int PACK_BITS = 6;
	localparam int LIT_LIMIT = 256;
	localparam int LIT_SHORT = 8;
	localparam int LIT_LONG = 16;
	localparam int FIRST_CODE = 3;
	localparam int END_CODE = 2;

	typedef struct packed {
		logic push;
		logic flush;
		logic bit_v;
		logic ovf;
	} pk_step_t;

	function automatic logic [6:0] uri_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'd65 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'd97 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'd48 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = 7'd43;
		end else begin
			r = 7'd45;
		end
		return r;
	endfunction

endpackage

@@ sv/lzsu_hash.sv @@
// Iterative multiplicative hash: one 11-bit key digit per cycle.
module lzsu_hash #(
	parameter int KW = 29,
	parameter int HB = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [HB-1:0] slot
);
	import lzsu_pkg::*;

	localparam int NSTEP = (KW + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int PB = HASH_SHIFT + HB;
	localparam int SW = $clog2(NSTEP + 1);

	logic [NSTEP*MUL_DIGIT-1:0] key_q;
	logic [PB-1:0] mc_q;
	logic [PB-1:0] acc_q;
	logic [SW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [MUL_DIGIT+PB-1:0] prod;

	assign prod = key_q[MUL_DIGIT-1:0] * mc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SW'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= (NSTEP*MUL_DIGIT)'(key);
			mc_q <= HASH_MUL[PB-1:0];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + prod[PB-1:0];
			key_q <= key_q >> MUL_DIGIT;
			mc_q <= mc_q << MUL_DIGIT;
		end
	end

	assign done = done_q;
	assign slot = acc_q[PB-1:HASH_SHIFT];

endmodule

@@ sv/lzsu_packer.sv @@
// Six-bit character packer with the output register.
module lzsu_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  lzsu_pkg::pk_step_t step,
	output logic              rdy,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [6:0] out_char, [7] zero
	output logic              m_tlast,  // last
	output logic              m_tuser   // overflow
);
	import lzsu_pkg::*;

	logic [5:0] buf_q;
	logic [2:0] pos_q;
	logic oval_q;
	logic [6:0] ch_q;
	logic last_q;
	logic ovf_q;
	logic [5:0] nb;
	logic [5:0] pad;
	logic load;

	assign rdy = !oval_q || m_tready;
	assign nb = {buf_q[4:0], step.bit_v};
	assign pad = buf_q << (3'd6 - pos_q);
	assign load = rdy && ((step.push && pos_q == 3'(PACK_BITS - 1)) || step.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			pos_q <= '0;
			oval_q <= 1'b0;
		end else begin
			if (load) begin
				oval_q <= 1'b1;
			end else if (m_tready) begin
				oval_q <= 1'b0;
			end
			if (rdy && step.push) begin
				if (pos_q == 3'(PACK_BITS - 1)) begin
					buf_q <= '0;
					pos_q <= '0;
				end else begin
					buf_q <= nb;
					pos_q <= pos_q + 1'b1;
				end
			end else if (rdy && step.flush) begin
				buf_q <= '0;
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && step.push && pos_q == 3'(PACK_BITS - 1)) begin
			ch_q <= uri_char(nb);
			last_q <= 1'b0;
			ovf_q <= step.ovf;
		end else if (rdy && step.flush) begin
			ch_q <= uri_char(pad);
			last_q <= 1'b1;
			ovf_q <= step.ovf;
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata = {1'b0, ch_q};
	assign m_tlast = last_q;
	assign m_tuser = ovf_q;

endmodule

@@ sv/lz_string_uri_compressor_core.sv @@
// Top level: sequencer, hashed dictionary and literal-mark memories.
//
//  channel | dir | transfer
//  s_*     | in  | tdata[15:0] char_code, tlast end_of_input, tuser no_char
//  m_*     | out | tdata[6:0] out_char, tlast last, tuser overflow
//
// Per unit: one or two dictionary lookups (a hash, then a slot read and check per
// probe each), then the emitted bits go through the packer; end of stream adds the
// flush. After reset and after every stream end the slot memory is cleared with
// s_tready low. A stalled m_tready holds the bit sequencer. HASH_SLOTS and
// DICT_ENTRIES must be powers of two; the core does not check this.
module lz_string_uri_compressor_core #(
	parameter int DICT_ENTRIES = 4096,
	parameter int HASH_SLOTS = 8192,
	parameter int UNIT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] char_code
	input  logic        s_tlast,  // end_of_input
	input  logic        s_tuser,  // no_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] out_char, [7] zero
	output logic        m_tlast,  // last
	output logic        m_tuser   // overflow
);
	import lzsu_pkg::*;

	localparam int PW = $clog2(DICT_ENTRIES);
	localparam int CW = $clog2(DICT_ENTRIES + 1);
	localparam int KW = 16 + CW;
	localparam int HB = $clog2(HASH_SLOTS);
	localparam int ENW = 1 + KW + PW;
	localparam int WDW = PW + 4;
	localparam int NW = $clog2(((WDW > 16) ? WDW : 16) + 1);

	localparam logic [4:0] S_CLR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_HASH = 5'd2;
	localparam logic [4:0] S_HWAIT = 5'd3;
	localparam logic [4:0] S_RD = 5'd4;
	localparam logic [4:0] S_CHK = 5'd5;
	localparam logic [4:0] S_URES = 5'd6;
	localparam logic [4:0] S_PRES = 5'd7;
	localparam logic [4:0] S_EPRD = 5'd8;
	localparam logic [4:0] S_EPCHK = 5'd9;
	localparam logic [4:0] S_EPLIT = 5'd10;
	localparam logic [4:0] S_TICK1 = 5'd11;
	localparam logic [4:0] S_TICK2 = 5'd12;
	localparam logic [4:0] S_EMIT = 5'd13;
	localparam logic [4:0] S_PADD = 5'd14;
	localparam logic [4:0] S_ENDCHK = 5'd15;
	localparam logic [4:0] S_FIN = 5'd16;
	localparam logic [4:0] S_FEND = 5'd17;
	localparam logic [4:0] S_FLUSH = 5'd18;

	logic [4:0] state_q;
	logic [4:0] ret_q;
	logic [4:0] ep_ret_q;
	logic [HB-1:0] clr_q;
	logic [15:0] unit_q;
	logic end_q;
	logic ph_q;
	logic [KW-1:0] key_q;
	logic [HB-1:0] slot_q;
	logic [HB-1:0] pc_q;
	logic found_q;
	logic empty_q;
	logic [PW-1:0] code_q;
	logic [PW-1:0] ucode_q;
	logic [PW-1:0] prefix_q;
	logic present_q;
	logic [15:0] punit_q;
	logic [CW-1:0] nfc_q;
	logic [WDW-1:0] wcd_q;
	logic [NW-1:0] cwid_q;
	logic ovf_q;
	logic [15:0] sh_q;
	logic [NW-1:0] cnt_q;

	logic [ENW-1:0] slot_mem [HASH_SLOTS];
	logic [ENW-1:0] rd_q;
	logic mk_mem [DICT_ENTRIES];
	logic mk_rd_q;

	logic h_start;
	logic h_done;
	logic [HB-1:0] h_slot;
	logic pk_rdy;
	pk_step_t step;

	logic e_used;
	logic [KW-1:0] e_key;
	logic [PW-1:0] e_code;
	logic full;
	logic can_add;
	logic sw_en;
	logic [HB-1:0] sw_addr;
	logic [ENW-1:0] sw_data;
	logic mw_en;
	logic [PW-1:0] mw_addr;
	logic mw_data;
	logic tick;
	logic pend;
	logic small_unit;
	logic [PW-1:0] uc_new;

	assign e_used = rd_q[ENW-1];
	assign e_key = rd_q[ENW-2 -: KW];
	assign e_code = rd_q[PW-1:0];
	assign full = nfc_q >= CW'(DICT_ENTRIES);
	assign can_add = !full && empty_q;
	assign small_unit = punit_q < 16'(LIT_LIMIT);
	assign pend = mk_rd_q && prefix_q >= PW'(FIRST_CODE) && CW'(prefix_q) < nfc_q;
	assign tick = (state_q == S_TICK1) || (state_q == S_TICK2);
	assign uc_new = found_q ? code_q : (can_add ? nfc_q[PW-1:0] : '0);
	assign s_tready = (state_q == S_IDLE);
	assign h_start = (state_q == S_HASH);

	always_comb begin
		sw_en = 1'b0;
		sw_addr = slot_q;
		sw_data = {1'b1, key_q, nfc_q[PW-1:0]};
		mw_en = 1'b0;
		mw_addr = nfc_q[PW-1:0];
		mw_data = 1'b0;
		case (state_q)
			S_CLR: begin
				sw_en = 1'b1;
				sw_addr = clr_q;
				sw_data = '0;
			end
			S_URES: begin
				sw_en = !found_q && can_add;
				mw_en = !found_q && can_add;
				mw_data = 1'b1;
			end
			S_PADD: begin
				sw_en = can_add;
				mw_en = can_add;
			end
			S_TICK1: begin
				mw_en = 1'b1;
				mw_addr = prefix_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sw_en) begin
			slot_mem[sw_addr] <= sw_data;
		end
		if (state_q == S_RD) begin
			rd_q <= slot_mem[slot_q];
		end
		if (mw_en) begin
			mk_mem[mw_addr] <= mw_data;
		end
		if (state_q == S_EPRD) begin
			mk_rd_q <= mk_mem[prefix_q];
		end
	end

	always_comb begin
		step = '0;
		step.ovf = ovf_q;
		step.bit_v = sh_q[0];
		step.push = (state_q == S_EMIT) && (cnt_q != '0);
		step.flush = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			ep_ret_q <= S_PADD;
			clr_q <= '0;
			end_q <= 1'b0;
			ph_q <= 1'b0;
			pc_q <= '0;
			found_q <= 1'b0;
			empty_q <= 1'b0;
			prefix_q <= '0;
			present_q <= 1'b0;
			nfc_q <= CW'(FIRST_CODE);
			wcd_q <= WDW'(2);
			cwid_q <= NW'(2);
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (tick && !ovf_q) begin
				if (wcd_q == WDW'(1)) begin
					wcd_q <= WDW'(1) << cwid_q;
					cwid_q <= cwid_q + 1'b1;
				end else begin
					wcd_q <= wcd_q - 1'b1;
				end
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HB'(HASH_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						end_q <= s_tlast;
						ph_q <= 1'b0;
						if (s_tuser) begin
							state_q <= s_tlast ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (h_done) begin
						pc_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (!e_used || e_key == key_q || pc_q == HB'(HASH_SLOTS - 1)) begin
						found_q <= e_used && e_key == key_q;
						empty_q <= !e_used;
						state_q <= ph_q ? S_PRES : S_URES;
					end else begin
						pc_q <= pc_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_URES: begin
					if (!found_q) begin
						if (can_add) begin
							nfc_q <= nfc_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (!present_q) begin
						prefix_q <= uc_new;
						present_q <= 1'b1;
						state_q <= S_ENDCHK;
					end else begin
						ph_q <= 1'b1;
						state_q <= S_HASH;
					end
				end
				S_PRES: begin
					if (found_q) begin
						prefix_q <= code_q;
						state_q <= S_ENDCHK;
					end else begin
						ep_ret_q <= S_PADD;
						state_q <= S_EPRD;
					end
				end
				S_EPRD: state_q <= S_EPCHK;
				S_EPCHK: begin
					cnt_q <= cwid_q;
					ret_q <= pend ? S_EPLIT : S_TICK2;
					state_q <= S_EMIT;
				end
				S_EPLIT: begin
					cnt_q <= small_unit ? NW'(LIT_SHORT) : NW'(LIT_LONG);
					ret_q <= S_TICK1;
					state_q <= S_EMIT;
				end
				S_TICK1: state_q <= S_TICK2;
				S_TICK2: state_q <= ep_ret_q;
				S_EMIT: begin
					if (cnt_q == '0) begin
						state_q <= ret_q;
					end else if (pk_rdy) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_PADD: begin
					if (can_add) begin
						nfc_q <= nfc_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					prefix_q <= ucode_q;
					state_q <= S_ENDCHK;
				end
				S_ENDCHK: state_q <= end_q ? S_FIN : S_IDLE;
				S_FIN: begin
					ep_ret_q <= S_FEND;
					state_q <= present_q ? S_EPRD : S_FEND;
				end
				S_FEND: begin
					cnt_q <= cwid_q;
					ret_q <= S_FLUSH;
					state_q <= S_EMIT;
				end
				S_FLUSH: begin
					if (pk_rdy) begin
						prefix_q <= '0;
						present_q <= 1'b0;
						nfc_q <= CW'(FIRST_CODE);
						wcd_q <= WDW'(2);
						cwid_q <= NW'(2);
						ovf_q <= 1'b0;
						clr_q <= '0;
						state_q <= S_CLR;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				unit_q <= 16'(s_tdata[UNIT_BITS-1:0]);
				key_q <= {CW'(0), 16'(s_tdata[UNIT_BITS-1:0])};
			end
			S_HWAIT: slot_q <= h_slot;
			S_CHK: begin
				code_q <= e_code;
				if (e_used && e_key != key_q) begin
					slot_q <= slot_q + 1'b1;
				end
			end
			S_URES: begin
				ucode_q <= uc_new;
				key_q <= {CW'(prefix_q) + 1'b1, unit_q};
				if (!present_q) begin
					punit_q <= unit_q;
				end
			end
			S_PADD: punit_q <= unit_q;
			S_EPCHK: begin
				if (pend) begin
					sh_q <= small_unit ? 16'd0 : 16'd1;
				end else begin
					sh_q <= 16'(prefix_q);
				end
			end
			S_EPLIT: sh_q <= punit_q;
			S_FEND: sh_q <= 16'(END_CODE);
			S_EMIT: begin
				if (cnt_q != '0 && pk_rdy) begin
					sh_q <= sh_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	lzsu_hash #(
		.KW(KW),
		.HB(HB)
	) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(h_start),
		.key(key_q),
		.done(h_done),
		.slot(h_slot)
	);

	lzsu_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rdy(pk_rdy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

@@ sv/lzsu_checker.sv @@
// Port-level checks for the compressor core, bound to the top level.
module lzsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transfer changed");

	// an empty transfer that does not end the stream leaves the input open
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !(s_tuser && !s_tlast) |=> !s_tready)
		else $error("input taken while a unit is in work");

	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7] && m_tdata[6:0] >= 7'd43)
		else $error("output character outside alphabet range");

endmodule

bind lz_string_uri_compressor_core lzsu_checker u_lzsu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast(s_tlast),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast),
	.m_tuser(m_tuser)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for lz_string_uri_compressor_core.
module tb;
	import lzsu_pkg::*;

	localparam int DICT_N = 4096;
	localparam int SLOT_N = 8192;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		logic [6:0] ch;
		logic       lst;
		logic       ovf;
	} uri_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [15:0] char_code
	logic        s_tlast = 1'b0;  // end_of_input
	logic        s_tuser = 1'b0;  // no_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // [6:0] out_char, [7] zero
	logic        m_tlast;  // last
	logic        m_tuser;  // overflow

	lz_string_uri_compressor_core DUT (.*);

	always #5 clk = ~clk;

	// compressor mirror
	bit        slot_full[SLOT_N];
	bit [63:0] slot_key[SLOT_N];
	int        slot_code[SLOT_N];
	bit        lit_mark[DICT_N];
	int        pfx_code, pfx_unit, free_code, widen_left, code_bits, pk_buf, pk_pos;
	bit        pfx_valid, dict_ovf;
	uri_char_t chars_due[$];
	string     uri_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+-$";

	int  errors = 0;
	int  cycles = 0;
	bit  calm = 1'b0;
	bit  stall_req = 1'b0;
	int  stall_left = 0;

	function automatic void clear_stream();
		foreach (slot_full[i]) slot_full[i] = 1'b0;
		foreach (lit_mark[i]) lit_mark[i] = 1'b0;
		pfx_code = 0; pfx_unit = 0; pfx_valid = 1'b0;
		free_code = FIRST_CODE; widen_left = 2; code_bits = 2;
		pk_buf = 0; pk_pos = 0; dict_ovf = 1'b0;
	endfunction

	function automatic int hash_slot(bit [63:0] key);
		bit [63:0] h;
		h = (key * HASH_MUL) >> HASH_SHIFT;
		return int'(h % SLOT_N);
	endfunction

	function automatic bit dict_lookup(bit [63:0] key, output int code);
		int s;
		s = hash_slot(key);
		for (int n = 0; n < SLOT_N; n++) begin
			if (!slot_full[s]) return 1'b0;
			if (slot_key[s] == key) begin
				code = slot_code[s];
				return 1'b1;
			end
			s = (s + 1) % SLOT_N;
		end
		return 1'b0;
	endfunction

	function automatic bit dict_insert(bit [63:0] key, output int code);
		int s;
		s = hash_slot(key);
		if (free_code >= DICT_N) begin
			dict_ovf = 1'b1;
			return 1'b0;
		end
		for (int n = 0; n < SLOT_N; n++) begin
			if (!slot_full[s]) begin
				slot_full[s] = 1'b1;
				slot_key[s] = key;
				slot_code[s] = free_code;
				code = free_code;
				free_code++;
				return 1'b1;
			end
			s = (s + 1) % SLOT_N;
		end
		dict_ovf = 1'b1;
		return 1'b0;
	endfunction

	function automatic void add_char(int v, bit lst);
		uri_char_t c;
		c.ch = 7'(uri_set[v & 63]);
		c.lst = lst;
		c.ovf = dict_ovf;
		chars_due.push_back(c);
	endfunction

	function automatic void pack_bits(int v, int n);
		for (int i = 0; i < n; i++) begin
			pk_buf = ((pk_buf << 1) | ((v >> i) & 1)) & 63;
			if (pk_pos >= PACK_BITS - 1) begin
				add_char(pk_buf, 1'b0);
				pk_pos = 0;
				pk_buf = 0;
			end else begin
				pk_pos++;
			end
		end
	endfunction

	function automatic void widen_step();
		if (dict_ovf) return;
		widen_left--;
		if (widen_left == 0) begin
			widen_left = 1 << code_bits;
			code_bits++;
		end
	endfunction

	function automatic void emit_prefix();
		int p;
		p = pfx_code % DICT_N;
		if (lit_mark[p]) begin
			if (pfx_unit < LIT_LIMIT) begin
				pack_bits(0, code_bits);
				pack_bits(pfx_unit, LIT_SHORT);
			end else begin
				pack_bits(1, code_bits);
				pack_bits(pfx_unit, LIT_LONG);
			end
			widen_step();
			lit_mark[p] = 1'b0;
		end else begin
			pack_bits(pfx_code, code_bits);
		end
		widen_step();
	endfunction

	function automatic void compress_item(int unit, bit eoi, bit nc);
		int ucode, pcode;
		bit [63:0] key;
		ucode = 0;
		pcode = 0;
		if (!nc) begin
			if (!dict_lookup(64'(unit), ucode)) begin
				if (dict_insert(64'(unit), ucode)) lit_mark[ucode % DICT_N] = 1'b1;
				else ucode = 0;
			end
			if (!pfx_valid) begin
				pfx_code = ucode;
				pfx_unit = unit;
				pfx_valid = 1'b1;
			end else begin
				key = ((64'(pfx_code) + 64'd1) << 16) | 64'(unit);
				if (dict_lookup(key, pcode)) begin
					pfx_code = pcode;
				end else begin
					emit_prefix();
					void'(dict_insert(key, pcode));
					pfx_code = ucode;
					pfx_unit = unit;
				end
			end
		end
		if (eoi) begin
			if (pfx_valid) emit_prefix();
			pack_bits(END_CODE, code_bits);
			for (int i = 0; i < PACK_BITS; i++) begin
				pk_buf = (pk_buf << 1) & 63;
				if (pk_pos >= PACK_BITS - 1) begin
					add_char(pk_buf, 1'b1);
					break;
				end
				pk_pos++;
			end
			clear_stream();
		end
	endfunction

	// one input transfer; valid stays high between back-to-back items
	task automatic send_item(input logic [15:0] unit, input bit eoi, input bit nc);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 8) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= unit;
		s_tlast <= eoi;
		s_tuser <= nc;
		do @(posedge clk); while (!s_tready);
		compress_item(int'(unit), eoi, nc);
	endtask

	task automatic drain_all();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (chars_due.size() == 0);
	endtask

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(255));
			default: return 16'($urandom_range(97, 100));
		endcase
	endfunction

	task automatic run_directed();
		send_item(16'd0, 1'b1, 1'b1);
		send_item(16'd5, 1'b0, 1'b1);
		send_item(16'd0, 1'b1, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0);
		foreach (s_tdata[b]) send_item(16'(1 << b), 1'b0, 1'b0);
		send_item(16'd255, 1'b0, 1'b0);
		send_item(16'd256, 1'b0, 1'b1);
		send_item(16'd256, 1'b1, 1'b0);
		repeat (6) send_item(16'h0061, 1'b0, 1'b0);
		send_item(16'h0000, 1'b1, 1'b1);
		drain_all();
	endtask

	task automatic run_random(input int n_items);
		int len;
		while (n_items > 0) begin
			len = $urandom_range(1, 14);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0) send_item(16'($urandom), 1'b0, 1'b1);
				else send_item(pick_unit(), 1'b0, 1'b0);
			end
			if ($urandom_range(3) == 0) send_item(16'($urandom), 1'b1, 1'b1);
			else send_item(pick_unit(), 1'b1, 1'b0);
			n_items -= len + 1;
		end
	endtask

	task automatic run_backpressure();
		stall_req = 1'b1;
		calm = 1'b1;
		for (int i = 0; i < 24; i++) send_item(16'(1000 + i * 77), 1'b0, 1'b0);
		send_item(16'd1, 1'b1, 1'b0);
		calm = 1'b0;
		drain_all();
	endtask

	always @(negedge clk) begin
		if (stall_req) begin
			stall_req = 1'b0;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 8;
		end
	end

	always @(posedge clk) begin
		uri_char_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (chars_due.size() == 0) begin
				$error("unexpected transfer: out_char %0d", m_tdata[6:0]);
				errors++;
			end else begin
				exp_c = chars_due.pop_front();
				if (m_tdata[6:0] !== exp_c.ch) begin
					$error("out_char exp %0d got %0d", exp_c.ch, m_tdata[6:0]);
					errors++;
				end
				if (m_tlast !== exp_c.lst) begin
					$error("last exp %0d got %0d", exp_c.lst, m_tlast);
					errors++;
				end
				if (m_tuser !== exp_c.ovf) begin
					$error("overflow exp %0d got %0d", exp_c.ovf, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clear_stream();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random(120);
		run_backpressure();
		calm = 1'b1;
		run_random(60);
		calm = 1'b0;
		run_random(130);
		drain_all();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
